/* rtl/core/utrf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the UART transceiver with receive ring.
// No dependencies; imported by utrf_ring and uart_transceiver_rx_fifo.
package utrf_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 16;

    localparam logic [CFG_W-1:0] BIT_PERIOD_RESET = 16'd16;

    // transmit slots: 0 start, 1..8 data, 9..10 stop
    localparam logic [3:0] TX_LAST_SLOT = 4'd10;
    localparam logic [3:0] TX_LAST_DATA = 4'd8;
    localparam logic [3:0] RX_DATA_BITS = 4'd8;

    typedef enum logic [3:0] {
        RX_IDLE = 4'b0001,
        RX_DATA = 4'b0010,
        RX_HOLD = 4'b0100,
        RX_STOP = 4'b1000
    } rx_phase_t;

    // per-tick command into the ring
    typedef struct packed {
        logic step;
        logic pop;
        logic push;
    } ring_cmd_t;

    // ring status toward the top level
    typedef struct packed {
        logic available;
        logic full;
        logic rd_valid;
        logic dropped;
    } ring_stat_t;

endpackage

/* rtl/core/utrf_ring.sv */
`timescale 1ns / 1ps
// Receive ring: byte memory with head/tail pointers, one slot kept free.
// Depends on utrf_pkg for the command and status structs.
module utrf_ring
    import utrf_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ring_cmd_t         cmd,
    input  logic [BYTE_W-1:0] push_data,
    output ring_stat_t        stat,
    output logic [BYTE_W-1:0] rd_data
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    logic [BYTE_W-1:0] mem [RING_DEPTH];
    logic [IW-1:0]     head_reg, tail_reg;
    logic [IW-1:0]     head_inc, tail_inc;
    logic              empty, full;
    logic              pop_ok, push_ok;
    logic              rd_valid_reg, dropped_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign empty    = (head_reg == tail_reg);
    assign full     = (head_inc == tail_reg);
    assign pop_ok   = cmd.step && cmd.pop && !empty;
    assign push_ok  = cmd.step && cmd.push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            rd_valid_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (push_ok)
                head_reg <= head_inc;
            if (pop_ok)
                tail_reg <= tail_inc;
            rd_valid_reg <= pop_ok;
            dropped_reg  <= cmd.push && full;
        end
    end

    // memory and read data: no reset
    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[head_reg] <= push_data;
        if (cmd.step)
            rd_data_reg <= pop_ok ? mem[tail_reg] : '0;
    end

    assign stat.available = !empty;
    assign stat.full      = full;
    assign stat.rd_valid  = rd_valid_reg;
    assign stat.dropped   = dropped_reg;
    assign rd_data        = rd_data_reg;

`ifndef SYNTHESIS
    a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && cmd.pop && empty |=> !rd_valid_reg && (rd_data_reg == '0))
        else $error("pop of empty ring returned data");
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> !empty)
        else $error("ring empty after accepted push");
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> $past(full))
        else $error("byte dropped while ring had room");
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !full || !empty)
        else $error("ring full and empty at once");
`endif

endmodule

/* rtl/core/uart_transceiver_rx_fifo.sv */
`timescale 1ns / 1ps
// Top level: UART transceiver, 8 data bits, no parity, two stop bits, with receive ring.
// Depends on utrf_pkg and utrf_ring.

// Each input beat is one time-base tick carrying the sampled receive line, a
// transmit request with its byte, and a ring pop. The block takes one beat per
// clock cycle as long as the result side keeps up: a beat lands in an input
// register, logic updates the transmitter, receiver and ring, and the result
// beat sits in a result register. A stalled result holds the whole state;
// the input register still takes one more beat. bit_period (ticks per serial
// bit) is written through cfg_we/cfg_wdata; the user must write it only while
// no beat is in flight, which the block itself does not enforce. Only
// its low TIMER_WIDTH bits count. The transmitter sends a low start bit, eight
// data bits LSB first and two high stop bits. The receiver arms on a low line,
// samples 1.5 bit periods later and then every bit period for eight bits,
// pushes the byte one period after the last sample and ignores the line for
// one more period. The ring holds RING_DEPTH-1 bytes; a byte that arrives when
// it is full is dropped and rx_dropped flags that tick. The ring needs no
// clearing pass after reset.
module uart_transceiver_rx_fifo
    import utrf_pkg::*;
#(
    parameter int RING_DEPTH  = 16,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [10] rx_pop, [15:11] zero
    input  logic [15:0]      s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] tx_line, [1] tx_busy, [9:2] read_data, [10] read_valid,
    // [11] rx_available, [12] rx_dropped, [15:13] zero
    output logic [15:0]      m_axis_tdata
);

    localparam int TW = TIMER_WIDTH;

    // configuration
    logic [CFG_W-1:0] bit_period_reg;
    logic [TW-1:0]    period;

    // input register
    logic              in_valid_reg;
    logic              in_rx_reg, in_start_reg, in_pop_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic              fire;

    // receiver
    rx_phase_t         rx_phase_reg, rx_phase_next;
    logic [TW:0]       rx_timer_reg, rx_timer_next, rx_timer_dec;
    logic [3:0]        rx_bits_reg, rx_bits_next;
    logic [BYTE_W-1:0] rx_shift_reg, rx_shift_next;
    logic              rx_push;

    // transmitter
    logic              tx_active_reg, tx_active_next;
    logic [TW-1:0]     tx_timer_reg, tx_timer_next, tx_timer_dec;
    logic [3:0]        tx_slot_reg, tx_slot_next, tx_slot_inc;
    logic [BYTE_W-1:0] tx_shift_reg, tx_shift_next;
    logic              tx_level_reg, tx_level_next;

    ring_cmd_t         ring_cmd;
    ring_stat_t        ring_stat;
    logic [BYTE_W-1:0] ring_rd_data;

    // fit the configured period to the timer width
    generate
        if (TW > CFG_W)
        begin : g_period_wide
            assign period = {{(TW - CFG_W){1'b0}}, bit_period_reg};
        end
        else if (TW == CFG_W)
        begin : g_period_same
            assign period = bit_period_reg;
        end
        else
        begin : g_period_narrow
            assign period = bit_period_reg[TW-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_period_reg <= BIT_PERIOD_RESET;
        else if (cfg_we)
            bit_period_reg <= cfg_wdata;
    end

    // Advance one tick when the input register holds a beat and the result
    // register is free or being drained this cycle.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_rx_reg    <= s_axis_tdata[0];
            in_start_reg <= s_axis_tdata[1];
            in_byte_reg  <= s_axis_tdata[9:2];
            in_pop_reg   <= s_axis_tdata[10];
        end
    end

    // Receiver: arm on a low line, count down to each sample point.
    assign rx_timer_dec = (rx_timer_reg != '0) ? rx_timer_reg - 1'b1 : '0;

    always_comb
    begin
        rx_phase_next = rx_phase_reg;
        rx_timer_next = rx_timer_reg;
        rx_bits_next  = rx_bits_reg;
        rx_shift_next = rx_shift_reg;
        rx_push       = 1'b0;
        unique case (rx_phase_reg)
            RX_IDLE:
            begin
                if (!in_rx_reg)
                begin
                    rx_phase_next = RX_DATA;
                    rx_timer_next = {1'b0, period} + {2'b00, period[TW-1:1]};
                    rx_bits_next  = '0;
                    rx_shift_next = '0;
                end
            end
            RX_DATA:
            begin
                rx_timer_next = rx_timer_dec;
                if (rx_timer_dec == '0)
                begin
                    rx_shift_next = {in_rx_reg, rx_shift_reg[BYTE_W-1:1]};
                    rx_bits_next  = rx_bits_reg + 1'b1;
                    rx_timer_next = {1'b0, period};
                    if (rx_bits_next >= RX_DATA_BITS)
                        rx_phase_next = RX_HOLD;
                end
            end
            RX_HOLD:
            begin
                rx_timer_next = rx_timer_dec;
                if (rx_timer_dec == '0)
                begin
                    rx_push       = 1'b1;
                    rx_timer_next = {1'b0, period};
                    rx_phase_next = RX_STOP;
                end
            end
            RX_STOP:
            begin
                rx_timer_next = rx_timer_dec;
                if (rx_timer_dec == '0)
                    rx_phase_next = RX_IDLE;
            end
            default:
            begin
                rx_phase_next = RX_IDLE;
            end
        endcase
    end

    // Transmitter: slot 0 start, 1..8 data LSB first, 9..10 stop.
    assign tx_timer_dec = (tx_timer_reg != '0) ? tx_timer_reg - 1'b1 : '0;
    assign tx_slot_inc  = tx_slot_reg + 1'b1;

    always_comb
    begin
        tx_active_next = tx_active_reg;
        tx_timer_next  = tx_timer_reg;
        tx_slot_next   = tx_slot_reg;
        tx_shift_next  = tx_shift_reg;
        tx_level_next  = tx_level_reg;
        if (!tx_active_reg)
        begin
            if (in_start_reg)
            begin
                tx_active_next = 1'b1;
                tx_shift_next  = in_byte_reg;
                tx_slot_next   = '0;
                tx_level_next  = 1'b0;
                tx_timer_next  = period;
            end
        end
        else
        begin
            tx_timer_next = tx_timer_dec;
            if (tx_timer_dec == '0)
            begin
                tx_slot_next  = tx_slot_inc;
                tx_timer_next = period;
                if (tx_slot_inc > TX_LAST_SLOT)
                begin
                    tx_active_next = 1'b0;
                    tx_slot_next   = '0;
                    tx_level_next  = 1'b1;
                end
                else if (tx_slot_inc <= TX_LAST_DATA)
                begin
                    tx_level_next = tx_shift_reg[0];
                    tx_shift_next = {1'b0, tx_shift_reg[BYTE_W-1:1]};
                end
                else
                begin
                    tx_level_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase_reg  <= RX_IDLE;
            rx_timer_reg  <= '0;
            rx_bits_reg   <= '0;
            rx_shift_reg  <= '0;
            tx_active_reg <= 1'b0;
            tx_timer_reg  <= '0;
            tx_slot_reg   <= '0;
            tx_shift_reg  <= '0;
            tx_level_reg  <= 1'b1;
        end
        else if (fire)
        begin
            rx_phase_reg  <= rx_phase_next;
            rx_timer_reg  <= rx_timer_next;
            rx_bits_reg   <= rx_bits_next;
            rx_shift_reg  <= rx_shift_next;
            tx_active_reg <= tx_active_next;
            tx_timer_reg  <= tx_timer_next;
            tx_slot_reg   <= tx_slot_next;
            tx_shift_reg  <= tx_shift_next;
            tx_level_reg  <= tx_level_next;
        end
    end

    // Pop and push both see the ring as it stood at the start of the tick.
    assign ring_cmd.step = fire;
    assign ring_cmd.pop  = in_pop_reg;
    assign ring_cmd.push = rx_push;

    utrf_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ring_cmd),
        .push_data (rx_shift_next),
        .stat      (ring_stat),
        .rd_data   (ring_rd_data)
    );

    // State only moves on a tick, so the registers themselves form the result beat.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, ring_stat.dropped, ring_stat.available,
                            ring_stat.rd_valid, ring_rd_data, tx_active_reg, tx_level_reg};

`ifndef SYNTHESIS
    a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
        !tx_active_reg |-> tx_level_reg)
        else $error("tx line low while transmitter idle");
    a_tx_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        tx_slot_reg <= TX_LAST_SLOT)
        else $error("transmit slot past last stop bit");
    a_rx_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_bits_reg <= RX_DATA_BITS)
        else $error("receiver sampled more than eight bits");
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(tx_timer_reg) && $stable(rx_timer_reg))
        else $error("state advanced while result stalled");
`endif

endmodule
